>>> rtl/sdc_pkg.sv
`default_nettype none
package sdc_pkg;
  localparam int MAX_SEGMENT = 256;
  localparam int ADDR_W      = $clog2(MAX_SEGMENT);
  localparam int COUNT_W     = 9;
  localparam int COLUMN_BITS = 16;
  localparam int COLOR_W     = 24;
  localparam logic [COUNT_W-1:0] SEG_LEN_RESET = COUNT_W'(192);

  typedef struct packed {
    logic start;      // latch pixel, handle line and segment start
    logic read;       // read table entry at scan index
    logic advance;    // step to next entry
    logic append;     // store new color at fill position
    logic hit_write;  // write back incremented count
    logic finish;     // update best, counters, maybe emit
  } cmd_t;

  typedef struct packed {
    logic at_end;     // scan index reached fill count
    logic hit;        // read entry matches pixel color
    logic emit;       // this pixel closes the segment
    logic out_free;   // output register can take a result
  } status_t;
endpackage
`default_nettype wire

>>> rtl/segment_dominant_color.sv
`default_nettype none
// Dominant color per segment of a pixel line. Pixels arrive one transaction at a
// time on s_axis; every segment_length pixels (1..256, reset 192) one result
// leaves on m_axis with the most frequent color, its count and the segment's
// start column. segment_length is to be written on the cfg channel while idle;
// the block itself does not enforce this. tuser set on a pixel starts a new line:
// the column restarts at zero and a partial segment is dropped. Ties go to the
// color that reached the top count first. The colors seen so far in a segment sit
// in a 256-entry table that is searched one entry at a time through its single
// registered read port. A finished result waits in an output register while the
// next pixel is taken.
module segment_dominant_color
  import sdc_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire        s_axis_tuser,   // line_start
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // dominant_red, dominant_green,
                                     // dominant_blue, dominant_count[32:24],
                                     // start_column[48:33], zero pad
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [8:0]  cfg_data        // segment_length
);
  cmd_t    cmd;
  status_t status;
  logic [COLOR_W-1:0]     out_color;
  logic [COUNT_W-1:0]     out_count;
  logic [COLUMN_BITS-1:0] out_start;

  assign cfg_ready = 1'b1;

  sdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // internal color packs red in the top byte, blue in the bottom
  sdc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_color      ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .in_line_start (s_axis_tuser),
    .cfg_we        (cfg_valid),
    .cfg_data      (cfg_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_color     (out_color),
    .out_count     (out_count),
    .out_start     (out_start)
  );

  assign m_axis_tdata = {7'd0, out_start, out_count,
                         out_color[7:0], out_color[15:8], out_color[23:16]};
endmodule
`default_nettype wire

>>> rtl/sdc_ctrl.sv
`default_nettype none
module sdc_ctrl
  import sdc_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_CMP    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.at_end) begin
          cmd.append = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cmd.read   = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status.hit) begin
          cmd.hit_write = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (!status.emit || status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/sdc_datapath.sv
`default_nettype none
module sdc_datapath
  import sdc_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  wire [COLOR_W-1:0]      in_color,
  input  wire                    in_line_start,
  input  wire                    cfg_we,
  input  wire [COUNT_W-1:0]      cfg_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [COLOR_W-1:0]     out_color,
  output logic [COUNT_W-1:0]     out_count,
  output logic [COLUMN_BITS-1:0] out_start
);
  logic [COLOR_W-1:0] color_mem [MAX_SEGMENT];
  logic [COUNT_W-1:0] count_mem [MAX_SEGMENT];

  logic [COUNT_W-1:0]     seg_len;
  logic [COLOR_W-1:0]     pix_color;
  logic [COUNT_W-1:0]     pix_cnt;      // pixels already in segment
  logic [COLUMN_BITS-1:0] column;
  logic [COLUMN_BITS-1:0] seg_start;
  logic [COLOR_W-1:0]     best_color;
  logic [COUNT_W-1:0]     best_count;
  logic [COUNT_W-1:0]     fill;
  logic [COUNT_W-1:0]     idx;
  logic [COLOR_W-1:0]     rd_color;
  logic [COUNT_W-1:0]     rd_count;
  logic [COUNT_W-1:0]     cnt;          // new count of the current color

  logic [COUNT_W-1:0]     eff_len;
  logic [COUNT_W-1:0]     pix_inc;
  logic                   take_best;
  logic [COLUMN_BITS-1:0] col_eff;
  logic [COUNT_W-1:0]     pix_eff;

  always_comb begin
    eff_len = seg_len;
    if (seg_len == '0) eff_len = COUNT_W'(1);
    else if (seg_len > COUNT_W'(MAX_SEGMENT)) eff_len = COUNT_W'(MAX_SEGMENT);
  end

  assign pix_inc   = pix_cnt + COUNT_W'(1);
  assign take_best = cnt > best_count;
  assign col_eff   = in_line_start ? '0 : column;
  assign pix_eff   = in_line_start ? '0 : pix_cnt;

  assign status.at_end   = (idx == fill);
  assign status.hit      = (rd_color == pix_color);
  assign status.emit     = (pix_inc >= eff_len);
  assign status.out_free = !out_valid || out_ready;

  // table storage, single write address: append happens at idx == fill
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      color_mem[idx[ADDR_W-1:0]] <= pix_color;
      count_mem[idx[ADDR_W-1:0]] <= COUNT_W'(1);
    end else if (cmd.hit_write) begin
      count_mem[idx[ADDR_W-1:0]] <= rd_count + COUNT_W'(1);
    end
    if (cmd.read) begin
      rd_color <= color_mem[idx[ADDR_W-1:0]];
      rd_count <= count_mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_color <= in_color;
      idx       <= '0;
    end else if (cmd.advance) begin
      idx <= idx + COUNT_W'(1);
    end
    if (cmd.append)         cnt <= COUNT_W'(1);
    else if (cmd.hit_write) cnt <= rd_count + COUNT_W'(1);
    if (cmd.finish && status.emit) begin
      out_color <= take_best ? pix_color : best_color;
      out_count <= take_best ? cnt : best_count;
      out_start <= seg_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len    <= SEG_LEN_RESET;
      pix_cnt    <= '0;
      column     <= '0;
      seg_start  <= '0;
      best_color <= '0;
      best_count <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) seg_len <= cfg_data;
      if (cmd.start) begin
        column  <= col_eff;
        pix_cnt <= pix_eff;
        if (pix_eff == '0) begin
          fill       <= '0;
          seg_start  <= col_eff;
          best_color <= '0;
          best_count <= '0;
        end
      end
      if (cmd.append) fill <= fill + COUNT_W'(1);
      if (cmd.finish) begin
        if (take_best) begin
          best_color <= pix_color;
          best_count <= cnt;
        end
        column  <= column + COLUMN_BITS'(1);
        pix_cnt <= status.emit ? '0 : pix_inc;
      end
      if (cmd.finish && status.emit) out_valid <= 1'b1;
      else if (out_ready)            out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> rtl/sdc_checker.sv
`default_nettype none
module sdc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [55:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[32:24] != 9'd0 && m_axis_tdata[32:24] <= 9'd256)
    else $error("dominant count out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
    else $error("pad bits set");

  a_busy_after_pixel: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("pixel taken while previous one in work");
endmodule

bind segment_dominant_color sdc_checker u_sdc_checker (.*);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import sdc_pkg::*;

  // Clock is 12 ns; the run is cut off at this many cycles if it hangs
  localparam int CYCLE_LIMIT  = 4000000;
  // A pixel may still be in the search when its segment emits nothing;
  // this wait covers the longest search, through a full table.
  localparam int DRAIN_CYCLES = 600;
  // Phase during which the result side holds off for a long stretch
  localparam int HOLD_PHASE   = 3;
  localparam int HOLD_CYCLES  = 500;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_start;
  } pixel_t;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [8:0]  count;
    logic [15:0] column;
  } dominant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic        s_axis_tuser = 1'b0; // line_start
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [55:0] m_axis_tdata;        // red, green, blue, count[32:24], column[48:33]
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  logic [8:0]  cfg_data = '0;       // segment_length

  segment_dominant_color uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pixels waiting to go out, and dominant colors still owed by the block
  pixel_t    pixel_q[$];
  dominant_t dominant_q[$];

  int mismatches = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int length_writes = 0;
  int cycles = 0;
  int phase_id = 0;
  bit quiet = 1'b0;   // no idling on either side in the closing phase

  // Shadow of the block: segment length register and the per-segment color table
  logic [8:0]  seg_len = SEG_LEN_RESET;
  logic [23:0] tab_color [MAX_SEGMENT];
  logic [8:0]  tab_count [MAX_SEGMENT];
  bit          tab_valid [MAX_SEGMENT];
  logic [8:0]  seg_pixels = '0;
  logic [15:0] col_ctr = '0;
  logic [15:0] seg_start = '0;
  logic [23:0] best_color = '0;
  logic [8:0]  best_count = '0;

  // Count one pixel into the running histogram; queue a dominant color when
  // the segment closes.
  task automatic count_pixel(input pixel_t p);
    logic [23:0] color;
    logic [8:0]  n;
    int          eff_len;
    bit          found;
    dominant_t   d;
    color = {p.red, p.green, p.blue};
    n = '0;
    found = 1'b0;
    if (p.line_start) begin
      col_ctr = '0;
      seg_pixels = '0;
    end
    if (seg_pixels == 0) begin
      foreach (tab_valid[i]) tab_valid[i] = 1'b0;
      seg_start = col_ctr;
      best_count = '0;
      best_color = '0;
    end
    foreach (tab_valid[i]) begin
      if (!found && tab_valid[i] && tab_color[i] == color) begin
        tab_count[i] = tab_count[i] + 9'd1;
        n = tab_count[i];
        found = 1'b1;
      end
    end
    if (!found) begin
      foreach (tab_valid[i]) begin
        if (!found && !tab_valid[i]) begin
          tab_valid[i] = 1'b1;
          tab_color[i] = color;
          tab_count[i] = 9'd1;
          n = 9'd1;
          found = 1'b1;
        end
      end
    end
    // strictly greater: ties stay with the color that got there first
    if (n > best_count) begin
      best_count = n;
      best_color = color;
    end
    seg_pixels = seg_pixels + 9'd1;
    col_ctr = col_ctr + 16'd1;
    eff_len = (seg_len == 0) ? 1 : ((seg_len > MAX_SEGMENT) ? MAX_SEGMENT : seg_len);
    if (seg_pixels >= eff_len) begin
      d.red = best_color[23:16];
      d.green = best_color[15:8];
      d.blue = best_color[7:0];
      d.count = best_count;
      d.column = seg_start;
      dominant_q.insert(dominant_q.size(), d);
      seg_pixels = '0;
    end
  endtask

  // Pixel driver: one transaction per accepted pixel, random idle bursts
  pixel_t cur_pixel;
  int     send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        count_pixel(cur_pixel);
        pixels_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 11) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          cur_pixel = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_pixel.blue, cur_pixel.green, cur_pixel.red};
          s_axis_tuser <= cur_pixel.line_start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: field checks against the oldest owed result, plus backpressure
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  dominant_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (dominant_q.size() == 0) begin
          mismatches++;
          $error("unexpected result transaction, tdata=%h", m_axis_tdata);
        end else begin
          want = dominant_q.pop_front();
          if (m_axis_tdata[7:0] !== want.red) begin
            mismatches++;
            $error("dominant_red: expected %0d, got %0d", want.red, m_axis_tdata[7:0]);
          end
          if (m_axis_tdata[15:8] !== want.green) begin
            mismatches++;
            $error("dominant_green: expected %0d, got %0d", want.green, m_axis_tdata[15:8]);
          end
          if (m_axis_tdata[23:16] !== want.blue) begin
            mismatches++;
            $error("dominant_blue: expected %0d, got %0d", want.blue, m_axis_tdata[23:16]);
          end
          if (m_axis_tdata[32:24] !== want.count) begin
            mismatches++;
            $error("dominant_count: expected %0d, got %0d", want.count, m_axis_tdata[32:24]);
          end
          if (m_axis_tdata[48:33] !== want.column) begin
            mismatches++;
            $error("start_column: expected %0d, got %0d", want.column, m_axis_tdata[48:33]);
          end
        end
      end
      // one long hold-off so the output register fills and the input stalls
      if (!hold_done && phase_id == HOLD_PHASE) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until the driver is empty and every owed result is in, then let
  // a pixel that emits nothing finish its table search.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || s_axis_tvalid || dominant_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [8:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seg_len = value;
    length_writes++;
  endtask

  task automatic add_pixel(input logic [23:0] rgb, input bit ls);
    pixel_t p;
    p.red = rgb[23:16];
    p.green = rgb[15:8];
    p.blue = rgb[7:0];
    p.line_start = ls;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  // Random pixels from a small palette (0 = any color); line starts at
  // 1 in ls_odds pixels (0 = never).
  task automatic random_pixels(input int count, input int palette_size, input int ls_odds);
    logic [23:0] palette[$];
    logic [23:0] rgb;
    repeat (palette_size) palette.insert(palette.size(), 24'($urandom()));
    repeat (count) begin
      if (palette_size == 0) rgb = 24'($urandom());
      else rgb = palette[$urandom_range(0, palette_size - 1)];
      add_pixel(rgb, ls_odds != 0 && $urandom_range(1, ls_odds) == 1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset length 192: a partial segment that a later line start drops
    add_pixel(24'hFFFFFF, 1'b1);
    add_pixel(24'h123456, 1'b0);
    add_pixel(24'hFFFFFF, 1'b0);

    // Length 0 acts as 1: every pixel is its own segment, extreme colors
    write_length(9'd0);
    add_pixel(24'h000000, 1'b1);
    add_pixel(24'hFFFFFF, 1'b0);
    add_pixel(24'hAA55AA, 1'b0);
    add_pixel(24'h55AA55, 1'b0);

    // Length 3: majority, three-way tie, line start dropping a partial segment
    write_length(9'd3);
    add_pixel(24'h010203, 1'b1);
    add_pixel(24'h0A0B0C, 1'b0);
    add_pixel(24'h0A0B0C, 1'b0);
    add_pixel(24'h300000, 1'b0);
    add_pixel(24'h003000, 1'b0);
    add_pixel(24'h000030, 1'b0);
    add_pixel(24'h808080, 1'b0);
    add_pixel(24'h7F7F7F, 1'b1);
    add_pixel(24'h808080, 1'b0);
    add_pixel(24'h7F7F7F, 1'b0);
    add_pixel(24'h808080, 1'b0);
    add_pixel(24'h808080, 1'b0);
    // Length 3 shrunk to 2 while idle in mid-segment: the next pixel closes it
    write_length(9'd2);
    add_pixel(24'hC0FFEE, 1'b0);
    add_pixel(24'hC0FFEE, 1'b0);

    phase_id = 1;
    write_length(9'd2);
    random_pixels(100, 3, 30);
    phase_id = 2;
    write_length(9'd5);
    random_pixels(200, 4, 40);
    write_length(9'd1);
    phase_id = HOLD_PHASE;   // long receiver hold-off lands here, length 1 fills fast
    random_pixels(150, 4, 20);
    phase_id = 4;
    write_length(9'd16);
    random_pixels(100, 8, 60);
    phase_id = 5;
    write_length(9'd256);
    random_pixels(260, 0, 0);
    phase_id = 6;
    write_length(9'd300);    // above the table size, acts as 256
    random_pixels(300, 16, 0);
    phase_id = 7;
    write_length(9'd511);
    random_pixels(270, 2, 0);
    phase_id = 8;
    write_length(9'd7);
    random_pixels(100, 5, 50);
    phase_id = 9;
    write_length(9'd4);
    quiet = 1'b1;
    random_pixels(200, 6, 40);

    wait_idle();
    $display("Covered %0d pixels and %0d dominant-color results across %0d length writes,",
             pixels_sent, results_seen, length_writes);
    $display("lengths 0..511 incl. out-of-range, line starts, ties and long backpressure.");
    if (mismatches == 0 && dominant_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> segment_dominant_color.f
rtl/sdc_pkg.sv
rtl/sdc_ctrl.sv
rtl/sdc_datapath.sv
rtl/segment_dominant_color.sv
rtl/sdc_checker.sv
tb/sv/tb.sv
